FILE: rtl/mhk_pkg.sv
// Package for the min-heap key update core.
// Holds beat payload types, the memory request type and the operation/status codes.
// No dependencies.
`default_nettype none

package mhk_pkg;

   localparam int KEY_W   = 32;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   // Heap positions never exceed the largest count the register can hold.
   localparam int POS_W   = 11;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_DEC   = 2'd1;
   localparam logic [1:0] FUNC_INC   = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;

   typedef struct packed {
      logic [1:0]               func;
      logic [INDEX_W-1:0]       index;
      logic signed [KEY_W-1:0]  key;
   } mhk_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [KEY_W-1:0]  value;
      logic [INDEX_W-1:0]       final_position;
   } mhk_rsp_type;

   typedef struct packed {
      logic                     rd;
      logic [POS_W-1:0]         rd_pos;
      logic                     wr;
      logic [POS_W-1:0]         wr_pos;
      logic signed [KEY_W-1:0]  wr_data;
   } mhk_mem_req_type;

endpackage

`default_nettype wire

FILE: rtl/min_heap_key_update_core.sv
// Top level of the min-heap key update core: count register, sequencer,
// key store and result register. Depends on mhk_pkg, mhk_seq and mhk_store.
//
//   channel | direction | handshake       | beat contents
//   req     | in        | valid / stall   | func, index, key
//   rsp     | out       | valid / stall   | status, value, final_position
//   csr     | in        | valid / ready   | heap_count
//
// A new request is taken only while the sequencer is idle, so one operation
// runs at a time. Write, read, a rejected key and an out-of-range index finish
// without a sift, while a decrease sifts up and an increase sifts down.
// Reset is synchronous and clears control state only; key store contents are
// undefined until written. A finished result waits in the output register
// while the next item is accepted; the sequencer holds only if it finishes
// again before that result is taken.
`default_nettype none

module min_heap_key_update_core #(
   parameter int DEPTH = 1024
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire mhk_pkg::mhk_req_type         req_payload,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output mhk_pkg::mhk_rsp_type              rsp_payload,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [mhk_pkg::COUNT_W-1:0]        csr_data
);
   import mhk_pkg::*;

   // A count above DEPTH acts as DEPTH. When DEPTH is beyond what the register
   // can hold, the cap never applies.
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] DEPTH_CAP =
      (DEPTH > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(DEPTH);

   logic [COUNT_W-1:0]       heap_count_ff, heap_count_in;
   logic [COUNT_W-1:0]       eff_count;
   logic                     rsp_valid_ff, rsp_valid_in;
   mhk_rsp_type              rsp_payload_ff, rsp_payload_in;

   logic                     seq_idle;
   logic                     seq_push;
   logic                     out_free;
   logic                     req_take;
   mhk_rsp_type              seq_result;
   mhk_mem_req_type          mem_req;
   logic signed [KEY_W-1:0]  rd_data;

   // The count is to be written only while the block is idle; the block itself
   // does not enforce this, so the csr channel is ready whenever reset is low.
   assign csr_ready     = !reset;
   assign heap_count_in = (csr_valid && csr_ready) ? csr_data : heap_count_ff;
   assign eff_count     = (heap_count_ff > DEPTH_CAP) ? DEPTH_CAP : heap_count_ff;

   assign req_stall = reset || !seq_idle;
   assign req_take  = req_valid && !req_stall;

   // The output register is free when it is empty or its beat is taken this cycle.
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in   = seq_push || (rsp_valid_ff && rsp_stall);
   assign rsp_payload_in = seq_push ? seq_result : rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         heap_count_ff <= heap_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   mhk_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .req       (req_payload),
      .eff_count (eff_count),
      .out_free  (out_free),
      .rd_data   (rd_data),
      .idle      (seq_idle),
      .push      (seq_push),
      .result    (seq_result),
      .mem_req   (mem_req)
   );

   mhk_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

FILE: rtl/mhk_store.sv
// Heap key store: one write port and one read port with registered read data.
// Depends on mhk_pkg.
`default_nettype none

module mhk_store #(
   parameter int DEPTH = 1024
) (
   input  wire                          clock,
   input  wire mhk_pkg::mhk_mem_req_type mem_req,
   output logic signed [mhk_pkg::KEY_W-1:0] rd_data
);
   import mhk_pkg::*;

   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   logic signed [KEY_W-1:0] mem [DEPTH];
   logic signed [KEY_W-1:0] rd_data_ff;

   // Positions handed in are always below DEPTH, so the size cast drops only zeros.
   always_ff @(posedge clock) begin
      if (mem_req.wr) begin
         mem[AW'(mem_req.wr_pos)] <= mem_req.wr_data;
      end
      if (mem_req.rd) begin
         rd_data_ff <= mem[AW'(mem_req.rd_pos)];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/mhk_seq.sv
// Sequencer for one heap operation: lookup, sift up, sift down, over one shared
// signed comparator and the key store with one read and one write port. Depends on mhk_pkg.
`default_nettype none

module mhk_seq (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire mhk_pkg::mhk_req_type        req,
   input  wire [mhk_pkg::COUNT_W-1:0]       eff_count,
   input  wire                              out_free,
   input  wire signed [mhk_pkg::KEY_W-1:0]  rd_data,
   output logic                             idle,
   output logic                             push,
   output mhk_pkg::mhk_rsp_type             result,
   output mhk_pkg::mhk_mem_req_type         mem_req
);
   import mhk_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOOK  = 4'd1;
   localparam logic [3:0] S_UP    = 4'd2;
   localparam logic [3:0] S_UPCMP = 4'd3;
   localparam logic [3:0] S_DOWN  = 4'd4;
   localparam logic [3:0] S_DNL   = 4'd5;
   localparam logic [3:0] S_DNR   = 4'd6;
   localparam logic [3:0] S_DNC   = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   logic [3:0]               state_ff, state_in;
   logic [1:0]               func_ff, func_in;
   logic signed [KEY_W-1:0]  key_ff, key_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [COUNT_W-1:0]       n_ff, n_in;
   logic signed [KEY_W-1:0]  child_ff, child_in;
   logic [POS_W-1:0]         cpos_ff, cpos_in;
   mhk_rsp_type              res_ff, res_in;

   logic signed [KEY_W-1:0]  lt_a, lt_b;
   logic                     lt;
   logic [POS_W:0]           left_pos, right_pos;
   logic [POS_W-1:0]         parent_pos;
   logic                     left_ok, right_ok;

   assign left_pos   = {pos_ff, 1'b1};
   assign right_pos  = left_pos + (POS_W+1)'(1);
   assign parent_pos = (pos_ff - POS_W'(1)) >> 1;
   assign left_ok    = left_pos < {1'b0, n_ff};
   assign right_ok   = right_pos < {1'b0, n_ff};

   // The one comparator; each state picks its operands.
   always_comb begin
      lt_a = key_ff;
      lt_b = rd_data;
      case (state_ff)
         S_LOOK: begin
            if (func_ff == FUNC_INC) begin
               lt_a = rd_data;
               lt_b = key_ff;
            end
         end
         S_DNR: begin
            lt_a = rd_data;
            lt_b = child_ff;
         end
         S_DNC: begin
            lt_a = child_ff;
            lt_b = key_ff;
         end
         default: begin
            lt_a = key_ff;
            lt_b = rd_data;
         end
      endcase
   end

   assign lt = lt_a < lt_b;

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      key_in   = key_ff;
      pos_in   = pos_ff;
      n_in     = n_ff;
      child_in = child_ff;
      cpos_in  = cpos_ff;
      res_in   = res_ff;
      push     = 1'b0;
      mem_req  = '{rd: 1'b0, rd_pos: pos_ff, wr: 1'b0, wr_pos: pos_ff, wr_data: key_ff};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in = req.func;
               key_in  = req.key;
               pos_in  = POS_W'(req.index);
               n_in    = eff_count;
               if (COUNT_W'(req.index) >= eff_count) begin
                  res_in   = '{status: ST_RANGE, value: '0, final_position: req.index};
                  state_in = S_EMIT;
               end else begin
                  mem_req.rd     = 1'b1;
                  mem_req.rd_pos = POS_W'(req.index);
                  state_in       = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            res_in.final_position = INDEX_W'(pos_ff);
            res_in.status         = ST_DONE;
            res_in.value          = key_ff;
            state_in              = S_EMIT;
            case (func_ff)
               FUNC_WRITE: begin
                  mem_req.wr = 1'b1;
               end
               FUNC_READ: begin
                  res_in.value = rd_data;
               end
               default: begin
                  if (!lt) begin
                     res_in.status = ST_REJECT;
                     res_in.value  = rd_data;
                  end else if (func_ff == FUNC_DEC) begin
                     state_in = S_UP;
                  end else begin
                     state_in = S_DOWN;
                  end
               end
            endcase
         end
         S_UP: begin
            // The moving key stays in key_ff; its slot is written only where it rests.
            if (pos_ff == '0) begin
               mem_req.wr            = 1'b1;
               res_in.final_position = INDEX_W'(pos_ff);
               state_in              = S_EMIT;
            end else begin
               mem_req.rd     = 1'b1;
               mem_req.rd_pos = parent_pos;
               state_in       = S_UPCMP;
            end
         end
         S_UPCMP: begin
            mem_req.wr = 1'b1;
            if (lt) begin
               mem_req.wr_data = rd_data;
               pos_in          = parent_pos;
               state_in        = S_UP;
            end else begin
               res_in.final_position = INDEX_W'(pos_ff);
               state_in              = S_EMIT;
            end
         end
         S_DOWN: begin
            if (!left_ok) begin
               mem_req.wr            = 1'b1;
               res_in.final_position = INDEX_W'(pos_ff);
               state_in              = S_EMIT;
            end else begin
               mem_req.rd     = 1'b1;
               mem_req.rd_pos = POS_W'(left_pos);
               state_in       = S_DNL;
            end
         end
         S_DNL: begin
            child_in = rd_data;
            cpos_in  = POS_W'(left_pos);
            if (right_ok) begin
               mem_req.rd     = 1'b1;
               mem_req.rd_pos = POS_W'(right_pos);
               state_in       = S_DNR;
            end else begin
               state_in = S_DNC;
            end
         end
         S_DNR: begin
            // Equal children keep the left one.
            if (lt) begin
               child_in = rd_data;
               cpos_in  = POS_W'(right_pos);
            end
            state_in = S_DNC;
         end
         S_DNC: begin
            mem_req.wr = 1'b1;
            if (lt) begin
               mem_req.wr_data = child_ff;
               pos_in          = cpos_ff;
               state_in        = S_DOWN;
            end else begin
               res_in.final_position = INDEX_W'(pos_ff);
               state_in              = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff  <= func_in;
      key_ff   <= key_in;
      pos_ff   <= pos_in;
      n_ff     <= n_in;
      child_ff <= child_in;
      cpos_ff  <= cpos_in;
      res_ff   <= res_in;
   end

   assign idle   = state_ff == S_IDLE;
   assign result = res_ff;

endmodule

`default_nettype wire

FILE: rtl/mhk_checker.sv
// Port-level checks for the min-heap key update core, bound to the top level.
// Depends on mhk_pkg and min_heap_key_update_core.
`default_nettype none

module mhk_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input wire mhk_pkg::mhk_rsp_type rsp_payload,
   input wire                   rsp_valid,
   input wire                   rsp_stall
);
   import mhk_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat dropped or changed while stalled");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an operation is under way");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == ST_DONE) || (rsp_payload.status == ST_REJECT)
                    || (rsp_payload.status == ST_RANGE))
      else $error("result carries an undefined status");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_RANGE) |-> rsp_payload.value == '0)
      else $error("out-of-range result carries a nonzero value");

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind min_heap_key_update_core mhk_checker u_mhk_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_payload (rsp_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall)
);

`default_nettype wire

FILE: test/min_heap_key_update_core_tb.sv
// Self-checking testbench for min_heap_key_update_core: key updates, sifts and range checks.
// A local heap predictor drives expected result beats; random idle and stall on both channels.
// Depends on mhk_pkg and the min_heap_key_update_core RTL.

module min_heap_key_update_core_tb;
   import mhk_pkg::*;

   localparam int HEAP_DEPTH     = 1024;
   localparam int RANDOM_ITEMS   = 600;
   localparam int SETTLE_CYCLES  = 50;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   mhk_req_type          req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   mhk_rsp_type          rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [COUNT_W-1:0]   csr_data = '0;

   // Predictor state: key store and count register as the block should hold them.
   logic signed [KEY_W-1:0] heap_keys [0:HEAP_DEPTH-1];
   logic [COUNT_W-1:0]      heap_count_q = '0;
   mhk_rsp_type             pending_results [$];
   mhk_rsp_type             want_rsp;

   int idle_mode   = 0;
   int stall_left  = 0;
   int idle_cycles = 0;
   int fail_count  = 0;
   int items_sent  = 0;
   int sift_moves  = 0;
   int rejects     = 0;
   int range_hits  = 0;
   int settings_used = 0;

   min_heap_key_update_core #(
      .DEPTH(HEAP_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned live_count();
      return (heap_count_q > HEAP_DEPTH) ? HEAP_DEPTH : heap_count_q;
   endfunction

   // Applies one operation to the predicted heap and returns the beat it should produce.
   function automatic mhk_rsp_type apply_heap_op(input mhk_req_type op);
      mhk_rsp_type             r;
      int unsigned             n, pos, up, lc, rc, m;
      logic signed [KEY_W-1:0] t;
      bit                      moving;
      n   = live_count();
      pos = op.index;
      r.status = ST_DONE;
      r.value  = '0;
      if (op.index >= n) begin
         r.status = ST_RANGE;
      end else begin
         case (op.func)
            FUNC_WRITE: begin
               heap_keys[pos] = op.key;
               r.value = op.key;
            end
            FUNC_READ: begin
               r.value = heap_keys[pos];
            end
            FUNC_DEC: begin
               if (op.key >= heap_keys[pos]) begin
                  r.status = ST_REJECT;
                  r.value  = heap_keys[pos];
               end else begin
                  heap_keys[pos] = op.key;
                  r.value = op.key;
                  moving = 1'b1;
                  while (moving && pos > 0) begin
                     up = (pos - 1) / 2;
                     if (heap_keys[pos] < heap_keys[up]) begin
                        t = heap_keys[pos];
                        heap_keys[pos] = heap_keys[up];
                        heap_keys[up] = t;
                        pos = up;
                     end else begin
                        moving = 1'b0;
                     end
                  end
               end
            end
            default: begin
               if (op.key <= heap_keys[pos]) begin
                  r.status = ST_REJECT;
                  r.value  = heap_keys[pos];
               end else begin
                  heap_keys[pos] = op.key;
                  r.value = op.key;
                  moving = 1'b1;
                  while (moving) begin
                     lc = 2 * pos + 1;
                     rc = lc + 1;
                     if (lc >= n) begin
                        moving = 1'b0;
                     end else begin
                        m = lc;
                        if (rc < n && heap_keys[rc] < heap_keys[lc]) m = rc;
                        if (heap_keys[m] < heap_keys[pos]) begin
                           t = heap_keys[pos];
                           heap_keys[pos] = heap_keys[m];
                           heap_keys[m] = t;
                           pos = m;
                        end else begin
                           moving = 1'b0;
                        end
                     end
                  end
               end
            end
         endcase
      end
      r.final_position = 10'(pos);
      return r;
   endfunction

   // Often no gap (mostly so in mode 1), some short ones, a few long ones; none at all in mode 0.
   function automatic int gap_length();
      int roll;
      if (idle_mode == 0) return 0;
      roll = $urandom_range(0, 99);
      if (roll < ((idle_mode == 2) ? 40 : 70)) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [KEY_W-1:0] key_below(input logic signed [KEY_W-1:0] cur);
      longint span, d;
      span = longint'(cur) + 64'sd2147483648;
      if (span == 0) return cur;
      if ($urandom_range(0, 1) == 1) d = $urandom_range(1, 64);
      else d = (longint'({$urandom, $urandom} >> 1) % span) + 1;
      if (d > span) d = span;
      return 32'(longint'(cur) - d);
   endfunction

   function automatic logic signed [KEY_W-1:0] key_above(input logic signed [KEY_W-1:0] cur);
      longint span, d;
      span = 64'sd2147483647 - longint'(cur);
      if (span == 0) return cur;
      if ($urandom_range(0, 1) == 1) d = $urandom_range(1, 64);
      else d = (longint'({$urandom, $urandom} >> 1) % span) + 1;
      if (d > span) d = span;
      return 32'(longint'(cur) + d);
   endfunction

   // Sends one request beat; valid stays high across back-to-back beats.
   task automatic send_op(input logic [1:0] func, input int unsigned index,
                          input logic signed [KEY_W-1:0] key);
      mhk_req_type op;
      mhk_rsp_type r;
      int          gap;
      op.func  = func;
      op.index = 10'(index);
      op.key   = key;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= op;
      do @(posedge clock); while (req_stall);
      r = apply_heap_op(op);
      pending_results.push_back(r);
      items_sent++;
      if (r.status == ST_REJECT) rejects++;
      if (r.status == ST_RANGE) range_hits++;
      if (r.status == ST_DONE && r.final_position != op.index) sift_moves++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] count_value);
      drain_results();
      csr_data  <= count_value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      heap_count_q = count_value;
      settings_used++;
   endtask

   // Loads positions 0..n-1, usually in nondecreasing order so the store is a valid heap.
   task automatic load_heap(input int unsigned n);
      longint                  acc, step;
      bit                      ordered;
      logic signed [KEY_W-1:0] key;
      ordered = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 1) == 1) begin
         acc  = longint'($urandom_range(0, 200)) - 100;
         step = 3;
      end else begin
         step = 64'd4294967295 / (n + 1);
         acc  = -64'sd2147483648 + $urandom_range(0, 1000);
      end
      for (int unsigned i = 0; i < n; i++) begin
         acc += $urandom_range(0, 32'(step));
         if (acc > 64'sd2147483647) acc = 64'sd2147483647;
         key = ordered ? 32'(acc) : $urandom;
         send_op(FUNC_WRITE, i, key);
      end
   endtask

   task automatic random_ops(input int unsigned total);
      int unsigned             n, idx, sel, roll;
      logic signed [KEY_W-1:0] cur, key;
      for (int unsigned i = 0; i < total; i++) begin
         n   = live_count();
         sel = $urandom_range(0, 99);
         idx = (n == 0) ? 0 : $urandom_range(0, n - 1);
         roll = $urandom_range(0, 9);
         if (n < HEAP_DEPTH && (n == 0 || sel < 8)) begin
            send_op(2'($urandom_range(0, 3)), $urandom_range(n, HEAP_DEPTH - 1), $urandom);
         end else if (sel < 40) begin
            cur = heap_keys[idx];
            key = (roll == 0) ? cur : (roll == 1) ? $urandom : key_below(cur);
            send_op(FUNC_DEC, idx, key);
         end else if (sel < 72) begin
            // Raising keys near the root gives the longest walks down.
            if ($urandom_range(0, 1) == 1) idx = $urandom_range(0, (n > 4) ? 3 : n - 1);
            cur = heap_keys[idx];
            key = (roll == 0) ? cur : (roll == 1) ? $urandom : key_above(cur);
            send_op(FUNC_INC, idx, key);
         end else if (sel < 86) begin
            key = (roll == 0) ? KEY_MIN : (roll == 1) ? KEY_MAX : $urandom;
            send_op(FUNC_WRITE, idx, key);
         end else begin
            send_op(FUNC_READ, idx, $urandom);
         end
      end
   endtask

   task automatic test_empty_heap();
      idle_mode = 0;
      send_op(FUNC_WRITE, 0, KEY_MAX);
      send_op(FUNC_DEC, 1023, KEY_MIN);
      send_op(FUNC_INC, 512, $urandom);
      send_op(FUNC_READ, 1, $urandom);
   endtask

   task automatic test_directed_updates();
      logic signed [KEY_W-1:0] seed_keys [0:6];
      seed_keys = '{32'sd10, 32'sd20, 32'sd20, 32'sd30, 32'sd40, 32'sd50, 32'sd60};
      idle_mode = 1;
      write_count(11'd7);
      for (int i = 0; i < 7; i++) send_op(FUNC_WRITE, i, seed_keys[i]);
      // Both children of the root are equal, so the raised root goes left.
      send_op(FUNC_INC, 0, 32'sd25);
      // A key equal to its parent does not move.
      send_op(FUNC_DEC, 6, 32'sd20);
      send_op(FUNC_DEC, 5, KEY_MIN);
      send_op(FUNC_INC, 0, KEY_MAX);
      // Updates that are not strictly smaller or larger are rejected.
      send_op(FUNC_DEC, 3, heap_keys[3]);
      send_op(FUNC_INC, 4, heap_keys[4]);
      send_op(FUNC_READ, 0, $urandom);
      send_op(FUNC_READ, 6, $urandom);
      send_op(FUNC_WRITE, 7, KEY_MIN);
      send_op(FUNC_DEC, 1023, KEY_MIN);
      send_op(FUNC_INC, 8, KEY_MAX);
      send_op(FUNC_READ, 7, $urandom);
   endtask

   task automatic test_full_depth();
      idle_mode = $urandom_range(0, 2);
      write_count(11'(HEAP_DEPTH));
      load_heap(HEAP_DEPTH);
      random_ops(150);
      // Counts past the store size behave as the store size.
      idle_mode = $urandom_range(0, 2);
      write_count(11'h7ff);
      random_ops(100);
      idle_mode = $urandom_range(0, 2);
      write_count(11'(HEAP_DEPTH + $urandom_range(1, 1022)));
      random_ops(60);
   endtask

   task automatic test_random_heaps();
      int          start;
      int unsigned cnt, roll;
      start = items_sent;
      while (items_sent < start + RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) cnt = 0;
         else if (roll < 20) cnt = $urandom_range(1, 3);
         else if (roll < 90) cnt = $urandom_range(4, 40);
         else cnt = $urandom_range(41, 300);
         idle_mode = $urandom_range(0, 2);
         write_count(11'(cnt));
         load_heap(cnt);
         random_ops(2 * cnt + $urandom_range(8, 24));
      end
   endtask

   // Result side: random stall bursts and comparison against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no expectation pending: %p", rsp_payload);
            fail_count++;
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_payload.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.value !== want_rsp.value) begin
               $error("value: expected %0d, got %0d", want_rsp.value, rsp_payload.value);
               fail_count++;
            end
            if (rsp_payload.final_position !== want_rsp.final_position) begin
               $error("final_position: expected %0d, got %0d",
                      want_rsp.final_position, rsp_payload.final_position);
               fail_count++;
            end
         end
      end
      if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = gap_length();
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("min_heap_key_update_core regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_heap();
      test_directed_updates();
      test_full_depth();
      test_random_heaps();
      drain_results();
      $display("%0d request beats over %0d count settings: %0d keys moved, %0d rejected,",
               items_sent, settings_used, sift_moves, rejects);
      $display("%0d out of range; %0d mismatches", range_hits, fail_count);
      if (fail_count == 0)
         $display("min_heap_key_update_core regression: pass");
      else
         $display("min_heap_key_update_core regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
rtl/mhk_pkg.sv
rtl/mhk_store.sv
rtl/mhk_seq.sv
rtl/min_heap_key_update_core.sv
rtl/mhk_checker.sv
test/min_heap_key_update_core_tb.sv
